// File: hw/rtl/emmrp_pkg.sv
// shared types, constants and functions of the meter response parser
`timescale 1ns / 1ps

package emmrp_pkg;

  localparam int MIN_FRAME_LEN = 23;
  localparam int CAP_FIRST     = 3;
  localparam int CAP_DEPTH     = 18;
  localparam int CAP_IDX_W     = $clog2(CAP_DEPTH);
  localparam int COUNT_W       = 6;
  localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [CFG_DATA_W-1:0] VOLTAGE_DB_RST = 16'd10;
  localparam logic [CFG_DATA_W-1:0] CURRENT_DB_RST = 16'd5;
  localparam logic [CFG_DATA_W-1:0] POWER_DB_RST   = 16'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLTAGE_DB = 2'd0,
    CFG_CURRENT_DB = 2'd1,
    CFG_POWER_DB   = 2'd2
  } cfg_reg_e;

  // one classified frame, handed from the front to the back
  typedef struct packed {
    logic        good;
    logic [15:0] voltage;
    logic [31:0] current;
    logic [31:0] power;
    logic [31:0] energy;
    logic [15:0] frequency;
    logic [15:0] pf;
  } frame_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] voltage;
    logic [CFG_DATA_W-1:0] current;
    logic [CFG_DATA_W-1:0] power;
  } deadband_t;

  // one byte through the reflected crc-16, bit by bit
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // absolute change compared against a deadband
  function automatic logic moved(input logic [31:0] a, input logic [31:0] b,
                                 input logic [CFG_DATA_W-1:0] band);
    logic [31:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d >= {16'h0000, band};
  endfunction

endpackage

// File: hw/rtl/emmrp_in_if.sv
// byte channel into the parser
`timescale 1ns / 1ps

interface emmrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// File: hw/rtl/emmrp_out_if.sv
// result channel out of the parser
`timescale 1ns / 1ps

interface emmrp_out_if;
  logic        valid;
  logic        ready;
  logic        frame_good;
  logic [15:0] voltage_raw;
  logic [31:0] current_raw;
  logic [31:0] power_raw;
  logic [31:0] energy_raw;
  logic [15:0] frequency_raw;
  logic [15:0] pf_raw;
  logic        voltage_moved;
  logic        current_moved;
  logic        power_moved;

  modport source (output valid, output frame_good, output voltage_raw, output current_raw,
                  output power_raw, output energy_raw, output frequency_raw, output pf_raw,
                  output voltage_moved, output current_moved, output power_moved,
                  input ready);
  modport sink   (input valid, input frame_good, input voltage_raw, input current_raw,
                  input power_raw, input energy_raw, input frequency_raw, input pf_raw,
                  input voltage_moved, input current_moved, input power_moved,
                  output ready);
endinterface

// File: hw/rtl/energy_meter_modbus_response_parser_core.sv
// top level of the energy meter modbus response parser
// usage:
//   byte_in_i carries one frame byte per item, frame_end marks the last byte
//   of a frame. a crc-16 (modbus flavour) runs over all but the last two
//   bytes, which hold the received crc low byte first. measured values sit
//   at fixed offsets (bytes 3 to 20) and are captured as the bytes pass.
//   res_out_o gives exactly one item per frame, at the byte marked
//   frame_end: frame_good plus, on a good frame, the raw fields and the
//   deadband flags for voltage, current and power. bytes without frame_end
//   give no item. a good frame updates the stored last values.
//   throughput: one byte per cycle while the queue is not full; the byte-wide
//   crc step in the front end sets the cycle. the result of a frame_end byte
//   goes from the front end into the two-entry frame queue, then the result register.
//   a stalled receiver holds the result register; the queue keeps up to two
//   more finished frames, after which ready drops and intake stops.
//   reset clears the crc, byte count, queue and last values and loads the
//   deadbands with 10, 5 and 2; capture bytes need no clearing because a
//   good frame always rewrites them first.
//   deadband registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
//   the user must write them while the block is idle; the block does not enforce it
`timescale 1ns / 1ps

module energy_meter_modbus_response_parser_core
  import emmrp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  emmrp_in_if.sink              byte_in_i,
  emmrp_out_if.source           res_out_o
);

  deadband_t band_q;
  logic      q_full, q_valid, push, pop;
  frame_t    frame_in, frame_head;

  // deadband registers; indexes beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q.voltage <= VOLTAGE_DB_RST;
      band_q.current <= CURRENT_DB_RST;
      band_q.power   <= POWER_DB_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VOLTAGE_DB: band_q.voltage <= cfg_data_i;
        CFG_CURRENT_DB: band_q.current <= cfg_data_i;
        CFG_POWER_DB:   band_q.power   <= cfg_data_i;
        default:        band_q         <= band_q;
      endcase
    end
  end

  // front end classifies each frame as its last byte arrives
  emmrp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_in_i (byte_in_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .frame_o   (frame_in)
  );

  // short queue lets the front keep taking bytes while the back is stalled
  emmrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (frame_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .frame_o (frame_head)
  );

  // back end applies deadbands in frame order and owns the last values
  emmrp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .band_i    (band_q),
    .q_valid_i (q_valid),
    .frame_i   (frame_head),
    .pop_o     (pop),
    .res_out_o (res_out_o)
  );

endmodule

// File: hw/rtl/emmrp_front.sv
// front end: byte intake, running crc, field capture and frame check
`timescale 1ns / 1ps

module emmrp_front
  import emmrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  emmrp_in_if.sink   byte_in_i,
  input  logic       q_full_i,
  output logic       push_o,
  output frame_t     frame_o
);

  logic [15:0]          crc_q, crc_d;
  logic [COUNT_W-1:0]   byte_count_q, byte_count_d;
  logic [7:0]           tail_q [2];
  logic [7:0]           cap_q [CAP_DEPTH];
  logic                 accept;
  logic [15:0]          crc_fed;
  logic [COUNT_W-1:0]   count_inc;
  logic                 good;
  logic                 cap_hit;
  logic [CAP_IDX_W-1:0] cap_idx;

  assign byte_in_i.ready = ~q_full_i;
  assign accept          = byte_in_i.valid & ~q_full_i;

  // the two newest bytes wait in the tail until the next byte proves they are not the crc
  assign crc_fed   = (byte_count_q >= COUNT_W'(2)) ? crc_feed(crc_q, tail_q[0]) : crc_q;
  assign count_inc = (byte_count_q < COUNT_W'(COUNT_MAX)) ? byte_count_q + COUNT_W'(1)
                                                          : byte_count_q;
  assign good = (count_inc >= COUNT_W'(MIN_FRAME_LEN)) &&
                ({byte_in_i.rx_byte, tail_q[1]} == crc_fed);

  assign cap_hit = (byte_count_q >= COUNT_W'(CAP_FIRST)) &&
                   (byte_count_q < COUNT_W'(CAP_FIRST + CAP_DEPTH));
  assign cap_idx = CAP_IDX_W'(byte_count_q - COUNT_W'(CAP_FIRST));

  always_comb begin
    if (byte_in_i.frame_end) begin
      crc_d        = CRC_INIT;
      byte_count_d = '0;
    end else begin
      crc_d        = crc_fed;
      byte_count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= CRC_INIT;
      byte_count_q <= '0;
      tail_q[0]    <= '0;
      tail_q[1]    <= '0;
    end else if (accept) begin
      crc_q        <= crc_d;
      byte_count_q <= byte_count_d;
      if (byte_in_i.frame_end) begin
        tail_q[0] <= '0;
        tail_q[1] <= '0;
      end else begin
        tail_q[0] <= tail_q[1];
        tail_q[1] <= byte_in_i.rx_byte;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cap_hit) begin
      cap_q[cap_idx] <= byte_in_i.rx_byte;
    end
  end

  // 32-bit fields arrive low word first, each word big-endian
  always_comb begin
    frame_o = '0;
    if (good) begin
      frame_o.good      = 1'b1;
      frame_o.voltage   = {cap_q[0], cap_q[1]};
      frame_o.current   = {cap_q[4], cap_q[5], cap_q[2], cap_q[3]};
      frame_o.power     = {cap_q[8], cap_q[9], cap_q[6], cap_q[7]};
      frame_o.energy    = {cap_q[12], cap_q[13], cap_q[10], cap_q[11]};
      frame_o.frequency = {cap_q[14], cap_q[15]};
      frame_o.pf        = {cap_q[16], cap_q[17]};
    end
  end

  assign push_o = accept & byte_in_i.frame_end;

endmodule

// File: hw/rtl/emmrp_queue.sv
// short frame queue between front and back
`timescale 1ns / 1ps

module emmrp_queue
  import emmrp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t frame_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   valid_o,
  output frame_t frame_o
);

  frame_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign frame_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (QUEUE_PTR_W + 1)'(1);
        2'b01:   count_q <= count_q - (QUEUE_PTR_W + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

endmodule

// File: hw/rtl/emmrp_back.sv
// back end: deadband compare, last-value update and result register
`timescale 1ns / 1ps

module emmrp_back
  import emmrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  deadband_t  band_i,
  input  logic       q_valid_i,
  input  frame_t     frame_i,
  output logic       pop_o,
  emmrp_out_if.source res_out_o
);

  logic        out_valid_q;
  frame_t      res_q;
  logic        v_moved_q, c_moved_q, p_moved_q;
  logic [15:0] last_voltage_q;
  logic [31:0] last_current_q, last_power_q;
  logic        v_moved, c_moved, p_moved;

  assign pop_o = q_valid_i & (~out_valid_q | res_out_o.ready);

  assign v_moved = frame_i.good &
                   moved({16'h0000, frame_i.voltage}, {16'h0000, last_voltage_q}, band_i.voltage);
  assign c_moved = frame_i.good & moved(frame_i.current, last_current_q, band_i.current);
  assign p_moved = frame_i.good & moved(frame_i.power, last_power_q, band_i.power);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      last_voltage_q <= '0;
      last_current_q <= '0;
      last_power_q   <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o && frame_i.good) begin
        last_voltage_q <= frame_i.voltage;
        last_current_q <= frame_i.current;
        last_power_q   <= frame_i.power;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q     <= frame_i;
      v_moved_q <= v_moved;
      c_moved_q <= c_moved;
      p_moved_q <= p_moved;
    end
  end

  assign res_out_o.valid         = out_valid_q;
  assign res_out_o.frame_good    = res_q.good;
  assign res_out_o.voltage_raw   = res_q.voltage;
  assign res_out_o.current_raw   = res_q.current;
  assign res_out_o.power_raw     = res_q.power;
  assign res_out_o.energy_raw    = res_q.energy;
  assign res_out_o.frequency_raw = res_q.frequency;
  assign res_out_o.pf_raw        = res_q.pf;
  assign res_out_o.voltage_moved = v_moved_q;
  assign res_out_o.current_moved = c_moved_q;
  assign res_out_o.power_moved   = p_moved_q;

endmodule
